// ===== rtl/ptt_pkg.sv =====
// Shared types and constants for the push-to-talk channel controller.
`timescale 1ns / 1ps
package ptt_pkg;

  // Item kinds on the input channel
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_PINS = 2'd2;

  // Whole-byte commands
  localparam logic [7:0] OP_RESET   = 8'h00;
  localparam logic [7:0] OP_VERSION = 8'h01;
  localparam logic [7:0] OP_PING    = 8'h02;
  localparam logic [7:0] OP_ADC0    = 8'h80;
  localparam logic [7:0] OP_ADC1    = 8'h81;

  // Channel commands: upper nibble is the group, lower nibble the channel
  localparam logic [3:0] GRP_INIT   = 4'h1;
  localparam logic [3:0] GRP_STATUS = 4'h2;
  localparam logic [3:0] GRP_SET    = 4'h3;
  localparam logic [3:0] GRP_CLEAR  = 4'h4;

  // Reply constants
  localparam logic [7:0] VERSION_MAJOR = 8'h01;
  localparam logic [7:0] VERSION_MINOR = 8'h00;
  localparam logic [7:0] PING_FIRST    = 8'h55;
  localparam logic [7:0] PING_SECOND   = 8'hAA;

  // Per-channel status flag bits
  localparam logic [2:0] FLAG_INIT    = 3'b001;
  localparam logic [2:0] FLAG_ACTIVE  = 3'b010;
  localparam logic [2:0] FLAG_TIMEOUT = 3'b100;

  // Number of channels that have key pins
  localparam int PIN_COUNT = 3;

  // Serial link phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LOW  = 2'd1,
    PH_HIGH = 2'd2
  } phase_t;

  // Outcome of one input item, handed from the core to the output stage
  typedef struct packed {
    logic       has_reply;
    logic       two_bytes;
    logic [7:0] first;
    logic [7:0] second;
    logic [2:0] drive;
  } res_pair_t;

  // One result transaction
  typedef struct packed {
    logic [7:0] reply_byte;
    logic       reply_valid;
    logic       last;
    logic [2:0] ptt_drive;
  } res_item_t;

endpackage

// ===== rtl/ptt_if.sv =====
// Handshake interfaces for the input items and the result items.
`timescale 1ns / 1ps
interface ptt_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] rx_byte;
  logic [2:0] key_pins;
  logic [9:0] adc_zero;
  logic [9:0] adc_one;

  modport source(output valid, cmd, rx_byte, key_pins, adc_zero, adc_one, input ready);
  modport sink(input valid, cmd, rx_byte, key_pins, adc_zero, adc_one, output ready);
  modport mon(input valid, ready, cmd, rx_byte, key_pins, adc_zero, adc_one);
endinterface

interface ptt_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] reply_byte;
  logic       reply_valid;
  logic       last;
  logic [2:0] ptt_drive;

  modport source(output valid, reply_byte, reply_valid, last, ptt_drive, input ready);
  modport sink(input valid, reply_byte, reply_valid, last, ptt_drive, output ready);
  modport mon(input valid, ready, reply_byte, reply_valid, last, ptt_drive);
endinterface

// ===== rtl/ptt_core.sv =====
// Input register, controller state and the per-item decode and update logic.
`timescale 1ns / 1ps
module ptt_core #(
  parameter int CHANNELS = 3
) (
  input  logic               clk,
  input  logic               rst,
  ptt_item_if.sink           item,
  input  logic               can_load,
  output logic               load,
  output ptt_pkg::res_pair_t pair
);
  import ptt_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PIN_N = (CHANNELS < PIN_COUNT) ? CHANNELS : PIN_COUNT;
  localparam logic [4:0] CH_COUNT = 5'(CHANNELS);

  // Input register
  logic       s1_valid;
  logic [1:0] s1_cmd;
  logic [7:0] s1_byte;
  logic [2:0] s1_pins;
  logic [9:0] s1_adc0;
  logic [9:0] s1_adc1;

  // Controller state
  phase_t                phase, phase_next;
  logic [CH_W-1:0]       pend, pend_next;
  logic [7:0]            low_hold, low_hold_next;
  logic [15:0]           limit [CHANNELS];
  logic [15:0]           limit_next [CHANNELS];
  logic [15:0]           elapsed [CHANNELS];
  logic [15:0]           elapsed_next [CHANNELS];
  logic [2:0]            flags [CHANNELS];
  logic [2:0]            flags_next [CHANNELS];
  logic [CHANNELS-1:0]   drive, drive_next;
  logic [2:0]            prev_pins, prev_pins_next;
  logic [CHANNELS+2:0]   drive_pad;

  assign load       = s1_valid && can_load;
  assign item.ready = !s1_valid || can_load;
  assign drive_pad  = {3'b000, drive_next};

  // Capture each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
    if (item.valid && item.ready) begin
      s1_cmd  <= item.cmd;
      s1_byte <= item.rx_byte;
      s1_pins <= item.key_pins;
      s1_adc0 <= item.adc_zero;
      s1_adc1 <= item.adc_one;
    end
  end

  // Decode the held transaction and work out the next state and replies
  always_comb begin
    logic [3:0]      nib;
    logic [3:0]      grp;
    logic            n_ok;
    logic [CH_W-1:0] nc;
    logic            was;
    logic            now;

    nib  = s1_byte[3:0];
    grp  = s1_byte[7:4];
    n_ok = ({1'b0, nib} < CH_COUNT);
    nc   = nib[CH_W-1:0];
    was  = 1'b0;
    now  = 1'b0;

    phase_next     = phase;
    pend_next      = pend;
    low_hold_next  = low_hold;
    drive_next     = drive;
    prev_pins_next = prev_pins;
    for (int i = 0; i < CHANNELS; i++) begin
      limit_next[i]   = limit[i];
      elapsed_next[i] = elapsed[i];
      flags_next[i]   = flags[i];
    end

    pair.has_reply = 1'b0;
    pair.two_bytes = 1'b0;
    pair.first     = 8'h00;
    pair.second    = 8'h00;

    unique case (s1_cmd)
      KIND_BYTE: begin
        if (phase == PH_LOW) begin
          low_hold_next = s1_byte;
          phase_next    = PH_HIGH;
        end else if (phase == PH_HIGH) begin
          limit_next[pend]   = {s1_byte, low_hold};
          elapsed_next[pend] = 16'h0000;
          flags_next[pend]   = FLAG_INIT;
          phase_next         = PH_IDLE;
        end else begin
          phase_next = PH_IDLE;
          if (s1_byte == OP_RESET) begin
            drive_next = '0;
            for (int i = 0; i < CHANNELS; i++) begin
              limit_next[i]   = 16'h0000;
              elapsed_next[i] = 16'h0000;
              flags_next[i]   = 3'b000;
            end
          end else if (s1_byte == OP_VERSION) begin
            pair.has_reply = 1'b1;
            pair.two_bytes = 1'b1;
            pair.first     = VERSION_MAJOR;
            pair.second    = VERSION_MINOR;
          end else if (s1_byte == OP_PING) begin
            pair.has_reply = 1'b1;
            pair.two_bytes = 1'b1;
            pair.first     = PING_FIRST;
            pair.second    = PING_SECOND;
          end else if (s1_byte == OP_ADC0) begin
            pair.has_reply = 1'b1;
            pair.two_bytes = 1'b1;
            pair.first     = s1_adc0[7:0];
            pair.second    = {6'b000000, s1_adc0[9:8]};
          end else if (s1_byte == OP_ADC1) begin
            pair.has_reply = 1'b1;
            pair.two_bytes = 1'b1;
            pair.first     = s1_adc1[7:0];
            pair.second    = {6'b000000, s1_adc1[9:8]};
          end else if (n_ok) begin
            if (grp == GRP_INIT) begin
              pend_next  = nc;
              phase_next = PH_LOW;
            end else if (grp == GRP_STATUS) begin
              pair.has_reply = 1'b1;
              pair.first     = {5'b00000, flags[nc]};
            end else if (grp == GRP_SET) begin
              if ((flags[nc] & FLAG_INIT) != 3'b000) begin
                drive_next[nc]   = 1'b1;
                elapsed_next[nc] = 16'h0000;
                flags_next[nc]   = (flags[nc] | FLAG_ACTIVE) & ~FLAG_TIMEOUT;
              end
            end else if (grp == GRP_CLEAR) begin
              drive_next[nc] = 1'b0;
              flags_next[nc] = flags[nc] & ~FLAG_ACTIVE;
            end
          end
        end
      end
      KIND_TICK: begin
        // Advance every keyed channel with a limit; drop it once it has run out
        for (int i = 0; i < CHANNELS; i++) begin
          if (limit[i] != 16'h0000 && drive[i]) begin
            elapsed_next[i] = elapsed[i] + 16'h0001;
            if (elapsed[i] >= limit[i]) begin
              drive_next[i] = 1'b0;
              flags_next[i] = (flags[i] | FLAG_TIMEOUT) & ~FLAG_ACTIVE;
            end
          end
        end
      end
      KIND_PINS: begin
        // Turn key edges into set and clear actions
        for (int i = 0; i < PIN_N; i++) begin
          was = prev_pins[i];
          now = s1_pins[i];
          if (was && !now) begin
            drive_next[i] = 1'b0;
            flags_next[i] = flags[i] & ~FLAG_ACTIVE;
          end else if (now && !was && ((flags[i] & FLAG_INIT) != 3'b000)) begin
            drive_next[i]   = 1'b1;
            elapsed_next[i] = 16'h0000;
            flags_next[i]   = (flags[i] | FLAG_ACTIVE) & ~FLAG_TIMEOUT;
          end
        end
        prev_pins_next = s1_pins;
      end
      default: begin
      end
    endcase

    pair.drive = drive_pad[2:0];
  end

  // Commit the state when the transaction moves on to the output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      pend      <= '0;
      low_hold  <= 8'h00;
      drive     <= '0;
      prev_pins <= 3'b000;
      for (int i = 0; i < CHANNELS; i++) begin
        limit[i]   <= 16'h0000;
        elapsed[i] <= 16'h0000;
        flags[i]   <= 3'b000;
      end
    end else if (load) begin
      phase     <= phase_next;
      pend      <= pend_next;
      low_hold  <= low_hold_next;
      drive     <= drive_next;
      prev_pins <= prev_pins_next;
      for (int i = 0; i < CHANNELS; i++) begin
        limit[i]   <= limit_next[i];
        elapsed[i] <= elapsed_next[i];
        flags[i]   <= flags_next[i];
      end
    end
  end

endmodule

// ===== rtl/ptt_out.sv =====
// Two-slot result register that sends one or two result transactions per item.
`timescale 1ns / 1ps
module ptt_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  ptt_pkg::res_pair_t pair,
  output logic               can_load,
  ptt_res_if.source          result
);
  import ptt_pkg::*;

  logic      a_valid;
  logic      b_valid;
  res_item_t slot_a;
  res_item_t slot_b;
  logic      take;

  assign take     = result.valid && result.ready;
  assign can_load = !a_valid || (!b_valid && result.ready);

  assign result.valid       = a_valid;
  assign result.reply_byte  = slot_a.reply_byte;
  assign result.reply_valid = slot_a.reply_valid;
  assign result.last        = slot_a.last;
  assign result.ptt_drive   = slot_a.ptt_drive;

  // Valid flags: load refills, a take advances the second slot forward
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (load) begin
      a_valid <= 1'b1;
      b_valid <= pair.two_bytes;
    end else if (take) begin
      a_valid <= b_valid;
      b_valid <= 1'b0;
    end
  end

  // Payload slots
  always_ff @(posedge clk) begin
    if (load) begin
      slot_a.reply_byte  <= pair.has_reply ? pair.first : 8'h00;
      slot_a.reply_valid <= pair.has_reply;
      slot_a.last        <= !pair.two_bytes;
      slot_a.ptt_drive   <= pair.drive;
      slot_b.reply_byte  <= pair.second;
      slot_b.reply_valid <= 1'b1;
      slot_b.last        <= 1'b1;
      slot_b.ptt_drive   <= pair.drive;
    end else if (take) begin
      slot_a <= slot_b;
    end
  end

endmodule

// ===== rtl/ptt_channel_controller_spi.sv =====
// Top level of the push-to-talk channel controller.
`timescale 1ns / 1ps
// Push-to-talk controller for up to CHANNELS transmitter channels.
// Input channel "item" carries one transaction per received command byte,
// one-second tick or key pin sample (cmd selects which). Output channel
// "result" returns one transaction per item with no reply, or one per reply
// byte (one or two), with last marking the final one; ptt_drive gives the
// keying levels of channels 0 to 2 after the item.
// An accepted item is held in the input register, decoded there and loaded
// into the result register, from which its first result is offered. One item
// per cycle when each item gives a single result and the receiver is ready;
// an item with a two-byte reply fills both slots of the result register, so
// the output port sets the rate.
// Reset (rst, synchronous) clears the link phase, every channel's limit,
// count and flags, the drive levels and the pin history, and empties both
// registers. When the receiver stalls, the result register holds its
// transactions and one further item waits in the input register; item.ready
// then drops until the result side drains.
module ptt_channel_controller_spi #(
  parameter int CHANNELS = 3
) (
  input  logic      clk,
  input  logic      rst,
  ptt_item_if.sink  item,
  ptt_res_if.source result
);
  import ptt_pkg::*;

  res_pair_t pair;
  logic      load;
  logic      can_load;

  ptt_core #(
    .CHANNELS(CHANNELS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .can_load(can_load),
    .load    (load),
    .pair    (pair)
  );

  ptt_out u_out (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .pair    (pair),
    .can_load(can_load),
    .result  (result)
  );

endmodule

// ===== rtl/ptt_checker.sv =====
// Port-level checks on the controller's result channel, bound to the top level.
`timescale 1ns / 1ps
module ptt_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       result_valid,
  input logic       result_ready,
  input logic [7:0] reply_byte,
  input logic       reply_valid,
  input logic       last,
  input logic [2:0] ptt_drive
);

  // Only two-byte replies have a first transaction without last
  a_first_has_reply: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |-> reply_valid)
    else $error("non-final result without a reply byte");

  // A transaction with no reply is a lone, zeroed one
  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !reply_valid) |-> (reply_byte == 8'h00 && last))
    else $error("empty result is not zeroed or not last");

  // The second byte of a pair follows straight after the first is taken
  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && !last) |=> result_valid)
    else $error("second reply byte missing");

  // Both transactions of a pair carry the same drive level
  a_pair_drive: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && !last)
      |=> (ptt_drive == $past(ptt_drive)))
    else $error("drive level differs within a reply pair");

  // Reset leaves nothing to send
  a_reset_empty: assert property (@(posedge clk)
    (rst && item_valid) |=> !result_valid)
    else $error("result offered straight after reset");

endmodule

bind ptt_channel_controller_spi ptt_checker u_ptt_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item.valid),
  .result_valid(result.valid),
  .result_ready(result.ready),
  .reply_byte  (result.reply_byte),
  .reply_valid (result.reply_valid),
  .last        (result.last),
  .ptt_drive   (result.ptt_drive)
);

// ===== sim/ptt_channel_controller_spi_test.sv =====
// Self-checking testbench for the push-to-talk channel controller: predictor, driver, monitor.
`timescale 1ns / 1ps
module ptt_channel_controller_spi_test;
  import ptt_pkg::*;

  localparam int CHANNELS    = 3;
  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD   = 400;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] rx_byte;
    logic [2:0] key_pins;
    logic [9:0] adc_zero;
    logic [9:0] adc_one;
  } ptt_item_t;

  logic clk;
  logic rst;

  ptt_item_if item_bus ();
  ptt_res_if  result_bus ();

  ptt_channel_controller_spi #(
    .CHANNELS(CHANNELS)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_bus),
    .result(result_bus)
  );

  // Stimulus, expectations and run control
  ptt_item_t pending_items[$];
  res_item_t expected_replies[$];
  int        mismatch_count;
  int        send_idle_pct;
  int        recv_stall_pct;
  int        hold_left;
  int        quiet_cycles;

  // Shadow state of the controller
  phase_t      link_state;
  logic [1:0]  init_channel;
  logic [7:0]  limit_low;
  logic [15:0] limit_secs [CHANNELS];
  logic [15:0] keyed_secs [CHANNELS];
  logic [2:0]  chan_flags [CHANNELS];
  logic [2:0]  keying;
  logic [2:0]  last_pins;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Clear drive, limits, counters and flags of every channel
  function automatic void clear_channels();
    keying = '0;
    for (int n = 0; n < CHANNELS; n++) begin
      limit_secs[n] = '0;
      keyed_secs[n] = '0;
      chan_flags[n] = '0;
    end
  endfunction

  // Key a channel, provided it has been initialised
  function automatic void key_channel(int n);
    if (n < CHANNELS && (chan_flags[n] & FLAG_INIT) != 0) begin
      keying[n]     = 1'b1;
      keyed_secs[n] = '0;
      chan_flags[n] = (chan_flags[n] | FLAG_ACTIVE) & ~FLAG_TIMEOUT;
    end
  endfunction

  function automatic void unkey_channel(int n);
    if (n < CHANNELS) begin
      keying[n]     = 1'b0;
      chan_flags[n] = chan_flags[n] & ~FLAG_ACTIVE;
    end
  endfunction

  // Advance the shadow state by one accepted transaction and queue its results
  function automatic void predict_controller(ptt_item_t it);
    logic [7:0]  reply [2];
    int          count;
    logic [3:0]  n;
    logic [15:0] before_tick;
    count = 0;
    n     = it.rx_byte[3:0];
    case (it.cmd)
      KIND_BYTE: begin
        if (link_state == PH_LOW) begin
          limit_low  = it.rx_byte;
          link_state = PH_HIGH;
        end else if (link_state == PH_HIGH) begin
          if (init_channel < CHANNELS) begin
            limit_secs[init_channel] = {it.rx_byte, limit_low};
            keyed_secs[init_channel] = '0;
            chan_flags[init_channel] = FLAG_INIT;
          end
          link_state = PH_IDLE;
        end else begin
          link_state = PH_IDLE;
          case (it.rx_byte)
            OP_RESET: clear_channels();
            OP_VERSION: begin
              reply[0] = VERSION_MAJOR;
              reply[1] = VERSION_MINOR;
              count    = 2;
            end
            OP_PING: begin
              reply[0] = PING_FIRST;
              reply[1] = PING_SECOND;
              count    = 2;
            end
            OP_ADC0: begin
              reply[0] = it.adc_zero[7:0];
              reply[1] = {6'b0, it.adc_zero[9:8]};
              count    = 2;
            end
            OP_ADC1: begin
              reply[0] = it.adc_one[7:0];
              reply[1] = {6'b0, it.adc_one[9:8]};
              count    = 2;
            end
            default: begin
              if (n < CHANNELS) begin
                case (it.rx_byte[7:4])
                  GRP_INIT: begin
                    init_channel = n[1:0];
                    link_state   = PH_LOW;
                  end
                  GRP_STATUS: begin
                    reply[0] = {5'b0, chan_flags[n[1:0]]};
                    count    = 1;
                  end
                  GRP_SET:   key_channel(int'(n));
                  GRP_CLEAR: unkey_channel(int'(n));
                  default: ;
                endcase
              end
            end
          endcase
        end
      end
      KIND_TICK: begin
        // Count keyed channels with a limit; drop those that reached it
        for (int c = 0; c < CHANNELS; c++) begin
          if (limit_secs[c] != 0 && keying[c]) begin
            before_tick   = keyed_secs[c];
            keyed_secs[c] = before_tick + 16'd1;
            if (before_tick >= limit_secs[c]) begin
              keying[c]     = 1'b0;
              chan_flags[c] = (chan_flags[c] | FLAG_TIMEOUT) & ~FLAG_ACTIVE;
            end
          end
        end
      end
      KIND_PINS: begin
        for (int c = 0; c < PIN_COUNT && c < CHANNELS; c++) begin
          if (last_pins[c] && !it.key_pins[c]) unkey_channel(c);
          else if (it.key_pins[c] && !last_pins[c]) key_channel(c);
        end
        last_pins = it.key_pins;
      end
      default: ;
    endcase
    if (count == 0) begin
      expected_replies.push_back('{reply_byte: 8'h00, reply_valid: 1'b0, last: 1'b1,
                                   ptt_drive: keying});
    end else begin
      for (int k = 0; k < count; k++) begin
        expected_replies.push_back('{reply_byte: reply[k], reply_valid: 1'b1,
                                     last: (k == count - 1), ptt_drive: keying});
      end
    end
  endfunction

  function automatic void compare_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  // Queue one transaction with fresh converter samples
  function automatic void queue_item(logic [1:0] cmd, logic [7:0] rx_byte,
                                     logic [2:0] pins);
    pending_items.push_back('{cmd: cmd, rx_byte: rx_byte, key_pins: pins,
                              adc_zero: 10'($urandom), adc_one: 10'($urandom)});
  endfunction

  function automatic void queue_byte(logic [7:0] b);
    queue_item(KIND_BYTE, b, 3'($urandom));
  endfunction

  // Mostly real channels, now and then any low nibble
  function automatic logic [3:0] pick_channel();
    if ($urandom_range(9) == 0) return 4'($urandom);
    return 4'($urandom_range(CHANNELS - 1));
  endfunction

  // Random traffic weighted towards well-formed command sequences
  function automatic void queue_traffic(int total);
    int         added;
    int         pick;
    logic [15:0] limit;
    added = 0;
    while (added < total) begin
      pick = $urandom_range(99);
      if (pick < 14) begin
        case ($urandom_range(4))
          0:       limit = '0;
          1, 2:    limit = 16'($urandom_range(4, 1));
          default: limit = 16'($urandom);
        endcase
        queue_byte({GRP_INIT, pick_channel()});
        queue_byte(limit[7:0]);
        queue_byte(limit[15:8]);
        added += 3;
      end else begin
        if (pick < 30)      queue_byte({GRP_SET, pick_channel()});
        else if (pick < 40) queue_byte({GRP_CLEAR, pick_channel()});
        else if (pick < 50) queue_byte({GRP_STATUS, pick_channel()});
        else if (pick < 58) begin
          case ($urandom_range(3))
            0:       queue_byte(OP_VERSION);
            1:       queue_byte(OP_PING);
            2:       queue_byte(OP_ADC0);
            default: queue_byte(OP_ADC1);
          endcase
        end
        else if (pick < 78) queue_item(KIND_TICK, 8'($urandom), 3'($urandom));
        else if (pick < 90) queue_item(KIND_PINS, 8'($urandom), 3'($urandom));
        else if (pick < 92) queue_byte(OP_RESET);
        else                queue_byte(8'($urandom));
        added++;
      end
    end
  endfunction

  // Drive input transactions from the pending queue
  always @(posedge clk) begin
    ptt_item_t next_item;
    if (rst) begin
      item_bus.valid <= 1'b0;
    end else if (!item_bus.valid || item_bus.ready) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = pending_items.pop_front();
        item_bus.valid    <= 1'b1;
        item_bus.cmd      <= next_item.cmd;
        item_bus.rx_byte  <= next_item.rx_byte;
        item_bus.key_pins <= next_item.key_pins;
        item_bus.adc_zero <= next_item.adc_zero;
        item_bus.adc_one  <= next_item.adc_one;
      end else begin
        item_bus.valid <= 1'b0;
      end
    end
  end

  // Drive ready, holding it low through a requested hold-off
  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      result_bus.ready <= 1'b0;
      hold_left--;
    end else begin
      result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Predict on accepted inputs, check accepted results
  always @(posedge clk) begin
    res_item_t want;
    if (!rst) begin
      if (item_bus.valid && item_bus.ready) begin
        predict_controller('{cmd: item_bus.cmd, rx_byte: item_bus.rx_byte,
                             key_pins: item_bus.key_pins, adc_zero: item_bus.adc_zero,
                             adc_one: item_bus.adc_one});
      end
      if (result_bus.valid && result_bus.ready) begin
        if (expected_replies.size() == 0) begin
          mismatch_count++;
          $display({"%0t: unexpected result, expected none, ",
                    "actual byte %0h valid %0b last %0b drive %0h"},
                   $time, result_bus.reply_byte, result_bus.reply_valid, result_bus.last,
                   result_bus.ptt_drive);
        end else begin
          want = expected_replies.pop_front();
          compare_field("reply_byte", want.reply_byte, result_bus.reply_byte);
          compare_field("reply_valid", 8'(want.reply_valid), 8'(result_bus.reply_valid));
          compare_field("last", 8'(want.last), 8'(result_bus.last));
          compare_field("ptt_drive", 8'(want.ptt_drive), 8'(result_bus.ptt_drive));
        end
      end
    end
  end

  // Abort when neither side has moved a transaction for too long
  always @(posedge clk) begin
    if (rst || (item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold the sender until every queued item has gone and every result has come
  task automatic drain();
    while (pending_items.size() > 0 || item_bus.valid || expected_replies.size() > 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_traffic(int send_pct, int stall_pct, int total);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    queue_traffic(total);
    drain();
  endtask

  initial begin
    rst               = 1'b1;
    item_bus.valid    = 1'b0;
    item_bus.cmd      = KIND_BYTE;
    item_bus.rx_byte  = '0;
    item_bus.key_pins = '0;
    item_bus.adc_zero = '0;
    item_bus.adc_one  = '0;
    result_bus.ready  = 1'b0;
    mismatch_count    = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    hold_left         = 0;
    quiet_cycles      = 0;
    link_state        = PH_IDLE;
    init_channel      = '0;
    limit_low         = '0;
    last_pins         = '0;
    clear_channels();
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // Directed: replies, converter extremes, init, timeout, pins, reset
    queue_byte(OP_VERSION);
    queue_byte(OP_PING);
    pending_items.push_back('{cmd: KIND_BYTE, rx_byte: OP_ADC0, key_pins: 3'b000,
                              adc_zero: 10'h3FF, adc_one: 10'h000});
    pending_items.push_back('{cmd: KIND_BYTE, rx_byte: OP_ADC1, key_pins: 3'b111,
                              adc_zero: 10'h000, adc_one: 10'h3FF});
    queue_byte({GRP_SET, 4'd1});        // set on an uninitialised channel
    queue_byte({GRP_INIT, 4'd0});
    queue_byte(8'hFF);                  // idle code taken as argument data
    queue_byte(8'h00);
    queue_byte({GRP_INIT, 4'd2});
    queue_byte(8'h02);
    queue_byte(8'h00);
    queue_byte({GRP_SET, 4'd2});
    repeat (3) queue_item(KIND_TICK, 8'hFF, 3'b000);
    queue_byte({GRP_STATUS, 4'd2});     // initialised and timed out
    queue_item(KIND_PINS, 8'h00, 3'b111);
    queue_byte({GRP_INIT, 4'd0});       // re-init while keyed
    queue_byte(8'h01);
    queue_byte(8'h00);
    queue_byte({GRP_STATUS, 4'd0});
    queue_item(KIND_PINS, 8'hFF, 3'b000);
    queue_byte({GRP_STATUS, 4'd3});     // channel out of range
    queue_byte(8'hFF);
    queue_byte(OP_RESET);
    queue_byte({GRP_STATUS, 4'd2});
    drain();

    run_traffic(0, 0, 300);
    run_traffic(52, 0, 300);
    run_traffic(0, 52, 300);
    run_traffic(15, 15, 300);

    // Long receiver hold-off while the sender keeps offering
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = LONG_HOLD;
    queue_traffic(60);
    drain();

    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
